// ----- hdl/bcdclk_pkg.sv -----
package bcdclk_pkg;

    localparam logic [7:0] FRAME_PERIOD_RESET = 8'd84;

    typedef enum logic [1:0] {
        EDIT_RUN = 2'd0,
        EDIT_SEC = 2'd1,
        EDIT_MIN = 2'd2,
        EDIT_HR  = 2'd3
    } edit_mode_t;

    // time of day, BCD digits
    typedef struct packed {
        logic [1:0] hr_tens;
        logic [3:0] hr_units;
        logic [2:0] min_tens;
        logic [3:0] min_units;
        logic [2:0] sec_tens;
        logic [3:0] sec_units;
    } clock_time_t;

    // one display result
    typedef struct packed {
        edit_mode_t  edit_field;
        logic        blank_hours;
        logic        blank_minutes;
        logic        blank_seconds;
        clock_time_t digits;
    } frame_result_t;

    localparam int RESULT_W = $bits(frame_result_t);

    localparam clock_time_t TIME_RESET = '{
        hr_tens:   2'd2,
        hr_units:  4'd3,
        min_tens:  3'd5,
        min_units: 4'd0,
        sec_tens:  3'd0,
        sec_units: 4'd0
    };

endpackage

// ----- hdl/bcdclk_core.sv -----
module bcdclk_core
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [7:0]                cfg_wdata,
    input  logic                      req_fire,
    input  logic [2:0]                buttons,     // mode, select, advance from bit 0
    output bcdclk_pkg::frame_result_t result
);

    logic [7:0]               frame_period_reg;
    bcdclk_pkg::clock_time_t  time_reg;
    bcdclk_pkg::clock_time_t  time_next;
    logic [7:0]               frame_index_reg;
    logic [7:0]               frame_index_next;
    logic [2:0]               prior_buttons_reg;
    bcdclk_pkg::edit_mode_t   edit_mode_reg;
    bcdclk_pkg::edit_mode_t   edit_mode_next;
    bcdclk_pkg::clock_time_t  time_ticked;
    logic [2:0]               rise;
    logic [8:0]               index_inc;
    logic                     blink;

    function automatic logic [3:0] next_units(input logic [3:0] d);
        return (d >= 4'd9) ? 4'd0 : d + 4'd1;
    endfunction

    function automatic logic [2:0] next_tens6(input logic [2:0] d);
        return (d >= 3'd5) ? 3'd0 : d + 3'd1;
    endfunction

    function automatic logic [1:0] next_tens3(input logic [1:0] d);
        return (d >= 2'd2) ? 2'd0 : d + 2'd1;
    endfunction

    function automatic bcdclk_pkg::clock_time_t bump_hours(input bcdclk_pkg::clock_time_t t);
        bcdclk_pkg::clock_time_t r;
        r = t;
        if (t.hr_units == 4'd9)
        begin
            r.hr_tens  = next_tens3(t.hr_tens);
            r.hr_units = 4'd0;
        end
        else if (t.hr_tens == 2'd2 && t.hr_units == 4'd3)
        begin
            // 23 wraps to 00
            r.hr_tens  = 2'd0;
            r.hr_units = 4'd0;
        end
        else
        begin
            r.hr_units = next_units(t.hr_units);
        end
        return r;
    endfunction

    function automatic bcdclk_pkg::clock_time_t bump_minutes(input bcdclk_pkg::clock_time_t t);
        bcdclk_pkg::clock_time_t r;
        r = t;
        if (t.min_units == 4'd9)
        begin
            r.min_tens = next_tens6(t.min_tens);
        end
        r.min_units = next_units(t.min_units);
        return r;
    endfunction

    function automatic bcdclk_pkg::clock_time_t tick_second(input bcdclk_pkg::clock_time_t t);
        bcdclk_pkg::clock_time_t r;
        r = t;
        if (t.sec_units == 4'd9)
        begin
            if (t.sec_tens == 3'd5)
            begin
                if (t.min_units == 4'd9 && t.min_tens == 3'd5)
                begin
                    r = bump_hours(r);
                end
                r = bump_minutes(r);
            end
            r.sec_tens = next_tens6(t.sec_tens);
        end
        r.sec_units = next_units(t.sec_units);
        return r;
    endfunction

    assign rise      = buttons & ~prior_buttons_reg;
    assign index_inc = {1'b0, frame_index_reg} + 9'd1;

    always_comb
    begin
        time_ticked = (frame_index_reg == 8'd1) ? tick_second(time_reg) : time_reg;
        time_next   = time_ticked;

        edit_mode_next = edit_mode_reg;
        if (rise[0])
        begin
            edit_mode_next = (edit_mode_reg != bcdclk_pkg::EDIT_RUN) ?
                             bcdclk_pkg::EDIT_RUN : bcdclk_pkg::EDIT_SEC;
        end
        if (rise[1])
        begin
            unique case (edit_mode_next)
                bcdclk_pkg::EDIT_RUN: edit_mode_next = bcdclk_pkg::EDIT_RUN;
                bcdclk_pkg::EDIT_SEC: edit_mode_next = bcdclk_pkg::EDIT_MIN;
                bcdclk_pkg::EDIT_MIN: edit_mode_next = bcdclk_pkg::EDIT_HR;
                bcdclk_pkg::EDIT_HR:  edit_mode_next = bcdclk_pkg::EDIT_SEC;
                default:              edit_mode_next = bcdclk_pkg::EDIT_RUN;
            endcase
        end
        if (rise[2])
        begin
            unique case (edit_mode_next)
                bcdclk_pkg::EDIT_RUN: time_next = time_ticked;
                bcdclk_pkg::EDIT_SEC:
                begin
                    time_next.sec_units = 4'd0;
                    time_next.sec_tens  = 3'd0;
                end
                bcdclk_pkg::EDIT_MIN: time_next = bump_minutes(time_ticked);
                bcdclk_pkg::EDIT_HR:  time_next = bump_hours(time_ticked);
                default:              time_next = time_ticked;
            endcase
        end

        if (index_inc >= {1'b0, frame_period_reg} || index_inc > 9'd255)
        begin
            frame_index_next = 8'd1;
        end
        else
        begin
            frame_index_next = index_inc[7:0];
        end

        blink = (edit_mode_next != bcdclk_pkg::EDIT_RUN) &&
                (frame_index_reg < {1'b0, frame_period_reg[7:1]});

        result.digits        = time_next;
        result.blank_seconds = blink && (edit_mode_next == bcdclk_pkg::EDIT_SEC);
        result.blank_minutes = blink && (edit_mode_next == bcdclk_pkg::EDIT_MIN);
        result.blank_hours   = blink && (edit_mode_next == bcdclk_pkg::EDIT_HR);
        result.edit_field    = edit_mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_period_reg <= bcdclk_pkg::FRAME_PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            frame_period_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg          <= bcdclk_pkg::TIME_RESET;
            frame_index_reg   <= 8'd1;
            prior_buttons_reg <= 3'd0;
            edit_mode_reg     <= bcdclk_pkg::EDIT_RUN;
        end
        else if (req_fire)
        begin
            time_reg          <= time_next;
            frame_index_reg   <= frame_index_next;
            prior_buttons_reg <= buttons;
            edit_mode_reg     <= edit_mode_next;
        end
    end

endmodule

// ----- hdl/bcdclk_skid.sv -----
module bcdclk_skid
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  bcdclk_pkg::frame_result_t in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output bcdclk_pkg::frame_result_t out_data
);

    logic                      main_valid_reg;
    logic                      main_valid_next;
    logic                      skid_valid_reg;
    logic                      skid_valid_next;
    bcdclk_pkg::frame_result_t main_data_reg;
    bcdclk_pkg::frame_result_t main_data_next;
    bcdclk_pkg::frame_result_t skid_data_reg;
    bcdclk_pkg::frame_result_t skid_data_next;
    logic                      in_fire;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (!main_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                // no request taken while the skid stage is full
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (in_fire)
            begin
                main_valid_next = 1'b1;
                main_data_next  = in_data;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
        else if (in_fire)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ----- hdl/bcd_clock_with_set_buttons.sv -----
// Channel   Dir  Width  Contents
// s_*       in   8      one display frame: three button levels
// m_*       out  32     time digits, blink blanks, edit field
// cfg_*     in   8      frame period
//
// One frame per clock while s_tready is high; the state update is one pass
// of logic from the state registers into the output register.
// Reset loads 23:50:00, run mode, frame index 1, frame period 84.
// A two-entry output buffer keeps s_tready high while one result waits;
// s_tready drops only when both entries are held by a stalled m side.
module bcd_clock_with_set_buttons
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // mode_button, select_button, advance_button, 5 zero bits
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // second_units[3:0], second_tens[6:4], minute_units[10:7],
                                   // minute_tens[13:11], hour_units[17:14], hour_tens[19:18],
                                   // blank_seconds[20], blank_minutes[21], blank_hours[22],
                                   // edit_field[24:23], 7 zero bits
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);

    bcdclk_pkg::frame_result_t core_result;
    bcdclk_pkg::frame_result_t out_result;
    logic                      req_fire;

    assign req_fire = s_tvalid && s_tready;

    bcdclk_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_fire  (req_fire),
        .buttons   (s_tdata[2:0]),
        .result    (core_result)
    );

    bcdclk_skid u_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (core_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {{(32 - bcdclk_pkg::RESULT_W){1'b0}}, out_result};

endmodule

// ----- hdl/bcdclk_check.sv -----
module bcdclk_check
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a stalled result stays presented
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_one_blank: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot0(m_tdata[22:20]))
        else $error("more than one pair blanked");

    // run mode never blanks
    a_run_no_blank: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[24:23] == 2'd0 |-> m_tdata[22:20] == 3'd0)
        else $error("blank set in run mode");

    a_blank_matches_field: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[20] |-> m_tdata[24:23] == 2'd1)
        else $error("seconds blanked while not editing seconds");

    a_hours_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[19:18] != 2'd3 && m_tdata[17:14] <= 4'd9)
        else $error("hour digits out of range");

endmodule

bind bcd_clock_with_set_buttons bcdclk_check u_bcdclk_check
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- bench/tb_bcd_clock_with_set_buttons.sv -----
module tb_bcd_clock_with_set_buttons;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MODE_BIT = 0;
    localparam int SEL_BIT  = 1;
    localparam int ADV_BIT  = 2;

    localparam logic [2:0] BTN_NONE = 3'b000;
    localparam logic [2:0] BTN_MODE = 3'b001;
    localparam logic [2:0] BTN_SEL  = 3'b010;
    localparam logic [2:0] BTN_ADV  = 3'b100;

    localparam int HOLD_OFF_CYCLES = 60;

    localparam bcdclk_pkg::clock_time_t LAST_SECOND = '{
        hr_tens:   2'd2,
        hr_units:  4'd3,
        min_tens:  3'd5,
        min_units: 4'd9,
        sec_tens:  3'd5,
        sec_units: 4'd9
    };

    // button presses walking every field, simultaneous presses, run-mode presses
    localparam logic [2:0] DIRECTED_PRESSES [25] = '{
        BTN_NONE, BTN_MODE, BTN_NONE, BTN_ADV, BTN_ADV,
        BTN_NONE, BTN_SEL, BTN_NONE, BTN_ADV, BTN_NONE,
        BTN_SEL, BTN_NONE, BTN_ADV, BTN_NONE, BTN_SEL,
        BTN_NONE, BTN_SEL | BTN_ADV, BTN_NONE, BTN_MODE | BTN_SEL | BTN_ADV, BTN_NONE,
        BTN_SEL | BTN_ADV, BTN_NONE, BTN_MODE | BTN_SEL, BTN_NONE, BTN_MODE
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;   // mode_button, select_button, advance_button, 5 zero bits
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // digits sec..hr, blank sec/min/hr, edit_field, zero pad
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = 8'd0;

    always #1 clk = ~clk;

    bcd_clock_with_set_buttons u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // clock model state
    bcdclk_pkg::clock_time_t now_time   = bcdclk_pkg::TIME_RESET;
    bcdclk_pkg::edit_mode_t  edit_state = bcdclk_pkg::EDIT_RUN;
    logic [7:0]              frame_idx  = 8'd1;
    logic [7:0]              period_reg = bcdclk_pkg::FRAME_PERIOD_RESET;
    logic [2:0]              prev_btn   = 3'b000;

    bcdclk_pkg::frame_result_t display_q[$];
    logic [2:0]                button_q[$];

    logic in_taken = 1'b0;
    bit   quiet    = 1'b0;
    bit   hold_req = 1'b0;

    int fails      = 0;
    int checked    = 0;
    int rollovers  = 0;
    int bp_cycles  = 0;
    int cfg_writes = 0;

    function automatic bcdclk_pkg::clock_time_t inc_hours(bcdclk_pkg::clock_time_t t);
        if (t.hr_units == 4'd9)
        begin
            t.hr_tens  = (t.hr_tens >= 2'd2) ? 2'd0 : t.hr_tens + 2'd1;
            t.hr_units = 4'd0;
        end
        else if (t.hr_tens == 2'd2 && t.hr_units == 4'd3)
        begin
            t.hr_tens  = 2'd0;
            t.hr_units = 4'd0;
        end
        else
            t.hr_units = t.hr_units + 4'd1;
        return t;
    endfunction

    function automatic bcdclk_pkg::clock_time_t inc_minutes(bcdclk_pkg::clock_time_t t);
        if (t.min_units == 4'd9)
        begin
            t.min_tens  = (t.min_tens >= 3'd5) ? 3'd0 : t.min_tens + 3'd1;
            t.min_units = 4'd0;
        end
        else
            t.min_units = t.min_units + 4'd1;
        return t;
    endfunction

    function automatic bcdclk_pkg::clock_time_t tick_second(bcdclk_pkg::clock_time_t t);
        if (t.sec_units == 4'd9)
        begin
            if (t.sec_tens == 3'd5)
            begin
                if (t.min_units == 4'd9 && t.min_tens == 3'd5)
                    t = inc_hours(t);
                t = inc_minutes(t);
            end
            t.sec_tens  = (t.sec_tens >= 3'd5) ? 3'd0 : t.sec_tens + 3'd1;
            t.sec_units = 4'd0;
        end
        else
            t.sec_units = t.sec_units + 4'd1;
        return t;
    endfunction

    task automatic predict_frame(input logic [2:0] btn,
                                 output bcdclk_pkg::frame_result_t res);
        logic [2:0] rise;
        logic [7:0] idx;
        logic [8:0] nxt;
        logic       blink;
        rise = btn & ~prev_btn;
        idx  = frame_idx;
        if (idx == 8'd1)
        begin
            if (now_time == LAST_SECOND)
                rollovers++;
            now_time = tick_second(now_time);
        end
        // edges are taken in order mode, select, advance
        if (rise[MODE_BIT])
            edit_state = (edit_state != bcdclk_pkg::EDIT_RUN) ?
                         bcdclk_pkg::EDIT_RUN : bcdclk_pkg::EDIT_SEC;
        if (rise[SEL_BIT] && edit_state != bcdclk_pkg::EDIT_RUN)
            edit_state = (edit_state == bcdclk_pkg::EDIT_HR) ? bcdclk_pkg::EDIT_SEC :
                         bcdclk_pkg::edit_mode_t'(edit_state + 2'd1);
        if (rise[ADV_BIT])
        begin
            case (edit_state)
                bcdclk_pkg::EDIT_SEC:
                begin
                    now_time.sec_units = 4'd0;
                    now_time.sec_tens  = 3'd0;
                end
                bcdclk_pkg::EDIT_MIN: now_time = inc_minutes(now_time);
                bcdclk_pkg::EDIT_HR:  now_time = inc_hours(now_time);
                default:  ;
            endcase
        end
        prev_btn = btn;

        blink = (edit_state != bcdclk_pkg::EDIT_RUN) && (idx < (period_reg >> 1));
        res.digits        = now_time;
        res.blank_seconds = blink && edit_state == bcdclk_pkg::EDIT_SEC;
        res.blank_minutes = blink && edit_state == bcdclk_pkg::EDIT_MIN;
        res.blank_hours   = blink && edit_state == bcdclk_pkg::EDIT_HR;
        res.edit_field    = edit_state;

        nxt = {1'b0, idx} + 9'd1;
        if (nxt >= {1'b0, period_reg} || nxt > 9'd255)
            nxt = 9'd1;
        frame_idx = nxt[7:0];
    endtask

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // monitor: check results, then predict for the request taken at this edge
    always @(posedge clk)
    begin
        bcdclk_pkg::frame_result_t got;
        bcdclk_pkg::frame_result_t want;
        bcdclk_pkg::frame_result_t fresh;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = bcdclk_pkg::frame_result_t'(m_tdata[bcdclk_pkg::RESULT_W-1:0]);
                if (display_q.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                end
                else
                begin
                    want = display_q.pop_front();
                    checked++;
                    check_field("second_units", 32'(want.digits.sec_units),
                                32'(got.digits.sec_units));
                    check_field("second_tens", 32'(want.digits.sec_tens),
                                32'(got.digits.sec_tens));
                    check_field("minute_units", 32'(want.digits.min_units),
                                32'(got.digits.min_units));
                    check_field("minute_tens", 32'(want.digits.min_tens),
                                32'(got.digits.min_tens));
                    check_field("hour_units", 32'(want.digits.hr_units),
                                32'(got.digits.hr_units));
                    check_field("hour_tens", 32'(want.digits.hr_tens),
                                32'(got.digits.hr_tens));
                    check_field("blank_seconds", 32'(want.blank_seconds),
                                32'(got.blank_seconds));
                    check_field("blank_minutes", 32'(want.blank_minutes),
                                32'(got.blank_minutes));
                    check_field("blank_hours", 32'(want.blank_hours),
                                32'(got.blank_hours));
                    check_field("edit_field", 32'(want.edit_field),
                                32'(got.edit_field));
                    check_field("pad bits", 32'd0, 32'(m_tdata[31:bcdclk_pkg::RESULT_W]));
                end
            end
            in_taken = s_tvalid && s_tready;
            if (in_taken)
            begin
                predict_frame(s_tdata[2:0], fresh);
                display_q.push_back(fresh);
            end
            if (s_tvalid && !s_tready)
                bp_cycles++;
            if (cfg_we)
                period_reg = cfg_wdata;
        end
    end

    // request driver
    int gap_left  = 0;
    bit send_idle = 1'b1;

    always @(negedge clk)
    begin
        if (rst_n && !(s_tvalid && !in_taken))
        begin
            if (!quiet && $urandom_range(0, 63) == 0)
                send_idle = !send_idle;
            if (gap_left > 0)
            begin
                s_tvalid <= 1'b0;
                gap_left--;
            end
            else if (button_q.size() == 0)
                s_tvalid <= 1'b0;
            else if (!quiet && send_idle && $urandom_range(0, 5) == 0)
            begin
                s_tvalid <= 1'b0;
                gap_left = $urandom_range(0, 6);
            end
            else
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {5'b00000, button_q.pop_front()};
            end
        end
    end

    // result receiver
    int stall_left = 0;
    int hold_left  = 0;
    bit recv_idle  = 1'b1;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req && hold_left == 0)
            begin
                hold_left = HOLD_OFF_CYCLES;
                hold_req  = 1'b0;
            end
            if (!quiet && $urandom_range(0, 63) == 0)
                recv_idle = !recv_idle;
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (!quiet && recv_idle && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(0, 6);
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic wait_drained();
        while (button_q.size() != 0 || s_tvalid || display_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_period(input logic [7:0] value);
        wait_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        cfg_writes++;
    endtask

    // mostly clean press/release pairs, some idle runs, some raw noise
    task automatic queue_presses(input int count);
        int         done;
        int         kind;
        int         hold;
        int         rel;
        logic [2:0] btn;
        done = 0;
        while (done < count)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                btn = BTN_MODE << $urandom_range(0, 2);
                if ($urandom_range(0, 4) == 0)
                    btn = btn | (BTN_MODE << $urandom_range(0, 2));
                hold = $urandom_range(1, 3);
                rel  = $urandom_range(1, 3);
                repeat (hold) button_q.push_back(btn);
                repeat (rel) button_q.push_back(BTN_NONE);
                done += hold + rel;
            end
            else if (kind <= 7)
            begin
                hold = $urandom_range(1, 30);
                repeat (hold) button_q.push_back(BTN_NONE);
                done += hold;
            end
            else
            begin
                hold = $urandom_range(1, 4);
                repeat (hold) button_q.push_back(3'($urandom_range(0, 7)));
                done += hold;
            end
        end
    endtask

    task automatic press(input logic [2:0] btn);
        button_q.push_back(btn);
        button_q.push_back(BTN_NONE);
    endtask

    // set 23:59:00 by the buttons, then let it run past midnight; call when idle
    task automatic queue_midnight(input int period);
        int mins;
        int hrs;
        mins = now_time.min_tens * 10 + now_time.min_units;
        hrs  = now_time.hr_tens * 10 + now_time.hr_units;
        button_q.push_back(BTN_NONE);
        if (edit_state != bcdclk_pkg::EDIT_RUN)
            press(BTN_MODE);
        press(BTN_MODE);
        press(BTN_ADV);
        press(BTN_SEL);
        repeat (59 - mins) press(BTN_ADV);
        press(BTN_SEL);
        repeat (23 - hrs) press(BTN_ADV);
        press(BTN_SEL);
        press(BTN_ADV);
        press(BTN_MODE);
        repeat (62 * (period - 1) + 2) button_q.push_back(BTN_NONE);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        foreach (DIRECTED_PRESSES[i])
            button_q.push_back(DIRECTED_PRESSES[i]);

        write_period(8'd255);
        queue_presses(200);

        // shortest period: frame index above it at the write
        write_period(8'd4);
        queue_presses(300);
        hold_req = 1'b1;

        write_period(8'd7);
        wait_drained();
        queue_midnight(7);
        queue_presses(100);

        write_period(8'($urandom_range(5, 254)));
        queue_presses(200);

        write_period(8'd5);
        queue_presses(150);

        write_period(bcdclk_pkg::FRAME_PERIOD_RESET);
        wait_drained();
        quiet = 1'b1;
        queue_presses(150);

        wait_drained();
        repeat (5) @(posedge clk);
        $display("Checked %0d frames over %0d period writes, %0d midnight rollovers seen.",
                 checked, cfg_writes, rollovers);
        $display("Input back-pressure observed on %0d cycles.", bp_cycles);
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
